// ===== rtl/rjae_pkg.sv =====
// shared constants, opcodes and status codes for the jump/alu execute step unit
// no dependencies; used by rjae_div and the execute step unit
package rjae_pkg;

	localparam int XLEN = 32;
	localparam int MEM_WORDS_DEF = 1024;
	localparam logic [XLEN-1:0] START_RESET = 32'h4000_0000;
	localparam logic [XLEN-1:0] PC_STEP = 32'd4;
	localparam int GPR_COUNT = 15;
	localparam logic [3:0] REG_PC = 4'd15;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_HALT = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	// full opcodes
	localparam logic [7:0] OP_HALT = 8'h00;
	localparam logic [7:0] OP_CALL = 8'h20;
	localparam logic [7:0] OP_CALLI = 8'h21;
	localparam logic [7:0] OP_XCHG = 8'h40;

	// opcode groups (high nibble)
	localparam logic [3:0] GRP_BRANCH = 4'h3;
	localparam logic [3:0] GRP_ARITH = 4'h5;
	localparam logic [3:0] GRP_LOGIC = 4'h6;

	// low nibble codes
	localparam logic [3:0] LO_ADD = 4'h0;
	localparam logic [3:0] LO_SUB = 4'h1;
	localparam logic [3:0] LO_MUL = 4'h2;
	localparam logic [3:0] LO_DIV = 4'h3;
	localparam logic [3:0] LO_NOT = 4'h0;
	localparam logic [3:0] LO_AND = 4'h1;
	localparam logic [3:0] LO_OR = 4'h2;
	localparam logic [3:0] LO_XOR = 4'h3;
	localparam logic [2:0] BR_JMP = 3'd0;
	localparam logic [2:0] BR_EQ = 3'd1;
	localparam logic [2:0] BR_NE = 3'd2;
	localparam logic [2:0] BR_GT = 3'd3;

	localparam logic OPN_LOAD = 1'b0;

	// sign extend the 12-bit displacement
	function automatic logic [XLEN-1:0] sext_d(input logic [11:0] d);
		return {{(XLEN-12){d[11]}}, d};
	endfunction

endpackage

// ===== rtl/rjae_div.sv =====
// unsigned restoring divider, one quotient bit per cycle
// depends on rjae_pkg for the data width
module rjae_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rjae_pkg::XLEN-1:0] dividend,
	input  logic [rjae_pkg::XLEN-1:0] divisor,
	output logic                      done,
	output logic [rjae_pkg::XLEN-1:0] quotient
);
	localparam int CW = $clog2(rjae_pkg::XLEN + 1);

	logic [CW-1:0] cnt_q;
	logic running_q;
	logic done_q;
	logic [rjae_pkg::XLEN-1:0] rem_q;
	logic [rjae_pkg::XLEN-1:0] quo_q;
	logic [rjae_pkg::XLEN-1:0] dvs_q;
	logic [rjae_pkg::XLEN:0] rem_sh;
	logic [rjae_pkg::XLEN:0] rem_sub;

	// one trial subtract per cycle
	assign rem_sh = {rem_q, quo_q[rjae_pkg::XLEN-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			running_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(rjae_pkg::XLEN);
				running_q <= 1'b1;
			end else if (running_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					running_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (running_q) begin
			if (!rem_sub[rjae_pkg::XLEN]) begin
				rem_q <= rem_sub[rjae_pkg::XLEN-1:0];
				quo_q <= {quo_q[rjae_pkg::XLEN-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[rjae_pkg::XLEN-1:0];
				quo_q <= {quo_q[rjae_pkg::XLEN-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/risc_jump_alu_execute_step_unit.sv =====
// execute step unit: word memory, register file memory and step sequencer
// depends on rjae_pkg and rjae_div
//
// Usage: a request is taken at a clock edge with start high and busy low.
// operation 0 writes load_word into the word memory at load_address
// (word index = load_address[..:2], wrapping over MEM_WORDS, a power of two).
// operation 1 executes the instruction at the program counter.
// Each request produces exactly one result: done is high for one cycle and
// status, next_pc, reg_written, reg_index, reg_value are valid in that cycle.
// The receiver cannot stall; results are never held.
// Sequence: a load, or a step while halted, reports done straight from idle;
// other steps go through S_DEC and S_RA to S_EX, which ends halt, call, direct
// and untaken branches and no-op codes; indirect call and taken indirect branch
// go to S_MEM, exchange to S_XCH, alu ops to S_WB; a nonzero divide waits in
// S_DIV on the divider, one bit per cycle. Fetch, register and indirect reads
// are synchronous; one request at a time. Configuration: cfg_valid/cfg_ready
// write cfg_data into the program counter and clear the halted flag; cfg_ready
// is low while busy and while a request is offered on start.
// Reset: registers read as zero (per-entry valid bits), pc = 0x40000000,
// not halted. Word memory contents are undefined until loaded.
module risc_jump_alu_execute_step_unit #(
	parameter int MEM_WORDS = rjae_pkg::MEM_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [31:0] load_address,
	input  logic [31:0] load_word,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] next_pc,
	output logic        reg_written,
	output logic [3:0]  reg_index,
	output logic [31:0] reg_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	localparam int IDXW = $clog2(MEM_WORDS);

	typedef enum logic [2:0] {
		S_IDLE, S_DEC, S_RA, S_EX, S_MEM, S_XCH, S_DIV, S_WB
	} state_t;

	state_t state_q;
	logic [31:0] pc_q;
	logic halted_q;
	logic done_q;
	logic [1:0] status_q;
	logic wr_q;
	logic [3:0] widx_q;
	logic [31:0] wval_q;
	logic [31:0] ins_q;
	logic [31:0] vb_q;
	logic [31:0] vc_q;
	logic [31:0] res_q;
	logic accept;

	// word memory
	logic [31:0] mem [MEM_WORDS];
	logic [31:0] mem_rd_q;
	logic mem_we;
	logic [IDXW-1:0] mem_wa;
	logic [IDXW-1:0] mem_ra;

	// register file memory, r0..r13 plus sp at 14
	logic [31:0] rf [rjae_pkg::GPR_COUNT];
	logic [rjae_pkg::GPR_COUNT-1:0] rf_vld_q;
	logic [31:0] rd0_q;
	logic [31:0] rd1_q;
	logic v0_q;
	logic v1_q;
	logic rf_we;
	logic [3:0] rf_wa;
	logic [31:0] rf_wd;
	logic [3:0] rf_ra0;
	logic [3:0] rf_ra1;

	// decoded fields
	logic [7:0] op;
	logic [3:0] hi;
	logic [3:0] lo;
	logic [3:0] ra;
	logic [3:0] rb;
	logic [3:0] rc;
	logic [31:0] dsp;
	logic [31:0] va;
	logic [31:0] sum_abd;
	logic [31:0] tgt;
	logic take;
	logic [31:0] alu_res;
	logic div_start;
	logic div_done;
	logic [31:0] div_quo;

	function automatic logic [31:0] rval(input logic [3:0] idx, input logic [31:0] data,
			input logic vld, input logic [31:0] pc);
		if (idx == rjae_pkg::REG_PC) return pc;
		return vld ? data : 32'd0;
	endfunction

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = !busy && !start;

	assign op = ins_q[31:24];
	assign hi = ins_q[31:28];
	assign lo = ins_q[27:24];
	assign ra = ins_q[23:20];
	assign rb = ins_q[19:16];
	assign rc = ins_q[15:12];
	assign dsp = rjae_pkg::sext_d(ins_q[11:0]);

	// operand a arrives on port 0 in the execute cycle
	assign va = rval(ra, rd0_q, v0_q, pc_q);
	assign sum_abd = va + vb_q + dsp;
	assign tgt = va + dsp;

	// branch condition
	always_comb begin
		case (lo[2:0])
			rjae_pkg::BR_JMP: take = 1'b1;
			rjae_pkg::BR_EQ: take = (vb_q == vc_q);
			rjae_pkg::BR_NE: take = (vb_q != vc_q);
			rjae_pkg::BR_GT: take = (vb_q > vc_q);
			default: take = 1'b0;
		endcase
		if (lo[2]) take = 1'b0;
		if (lo[3] && lo[2]) take = 1'b0;
	end

	// alu result, divide result comes from the divider
	always_comb begin
		alu_res = 32'd0;
		if (hi == rjae_pkg::GRP_ARITH) begin
			case (lo)
				rjae_pkg::LO_ADD: alu_res = vb_q + vc_q;
				rjae_pkg::LO_SUB: alu_res = vb_q - vc_q;
				rjae_pkg::LO_MUL: alu_res = vb_q * vc_q;
				default: alu_res = 32'd0;
			endcase
		end else begin
			case (lo)
				rjae_pkg::LO_NOT: alu_res = ~vb_q;
				rjae_pkg::LO_AND: alu_res = vb_q & vc_q;
				rjae_pkg::LO_OR: alu_res = vb_q | vc_q;
				rjae_pkg::LO_XOR: alu_res = vb_q ^ vc_q;
				default: alu_res = 32'd0;
			endcase
		end
	end

	assign div_start = (state_q == S_EX) && (hi == rjae_pkg::GRP_ARITH)
		&& (lo == rjae_pkg::LO_DIV) && (vc_q != 32'd0);

	// memory port control
	always_comb begin
		mem_we = accept && (operation == rjae_pkg::OPN_LOAD);
		mem_wa = load_address[IDXW+1:2];
		if (state_q == S_EX) begin
			mem_ra = (op == rjae_pkg::OP_CALLI) ? sum_abd[IDXW+1:2] : tgt[IDXW+1:2];
		end else begin
			mem_ra = pc_q[IDXW+1:2];
		end
	end

	// register file port control; writes never overlap reads of the same step
	always_comb begin
		rf_ra0 = (state_q == S_DEC) ? mem_rd_q[19:16] : ra;
		rf_ra1 = mem_rd_q[15:12];
		rf_we = 1'b0;
		rf_wa = ra;
		rf_wd = res_q;
		case (state_q)
			S_EX: begin
				if (op == rjae_pkg::OP_XCHG && rb != rjae_pkg::REG_PC) begin
					rf_we = 1'b1;
					rf_wa = rb;
					rf_wd = vc_q;
				end
			end
			S_XCH: begin
				if (rc != rjae_pkg::REG_PC) begin
					rf_we = 1'b1;
					rf_wa = rc;
					rf_wd = vb_q;
				end
			end
			S_WB: begin
				rf_we = (ra != rjae_pkg::REG_PC);
			end
			default: rf_we = 1'b0;
		endcase
	end

	// word memory, synchronous read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= load_word;
		end
		mem_rd_q <= mem[mem_ra];
	end

	// register file storage, synchronous read on two ports
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf[rf_wa] <= rf_wd;
		end
		rd0_q <= rf[rf_ra0];
		rd1_q <= rf[rf_ra1];
	end

	// register valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			if (rf_we) begin
				rf_vld_q[rf_wa] <= 1'b1;
			end
			v0_q <= rf_vld_q[rf_ra0];
			v1_q <= rf_vld_q[rf_ra1];
		end
	end

	rjae_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (vb_q),
		.divisor  (vc_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// step sequencer with result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= rjae_pkg::START_RESET;
			halted_q <= 1'b0;
			done_q <= 1'b0;
			status_q <= rjae_pkg::ST_OK;
			wr_q <= 1'b0;
			widx_q <= '0;
			wval_q <= '0;
			ins_q <= '0;
			vb_q <= '0;
			vc_q <= '0;
			res_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						pc_q <= cfg_data;
						halted_q <= 1'b0;
					end
					if (accept) begin
						status_q <= halted_q ? rjae_pkg::ST_HALT : rjae_pkg::ST_OK;
						wr_q <= 1'b0;
						widx_q <= '0;
						wval_q <= '0;
						if (operation == rjae_pkg::OPN_LOAD || halted_q) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_DEC;
						end
					end
				end
				S_DEC: begin
					ins_q <= mem_rd_q;
					pc_q <= pc_q + rjae_pkg::PC_STEP;
					state_q <= S_RA;
				end
				S_RA: begin
					vb_q <= rval(rb, rd0_q, v0_q, pc_q);
					vc_q <= rval(rc, rd1_q, v1_q, pc_q);
					state_q <= S_EX;
				end
				S_EX: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
					if (op == rjae_pkg::OP_HALT) begin
						halted_q <= 1'b1;
						status_q <= rjae_pkg::ST_HALT;
					end else if (op == rjae_pkg::OP_CALL) begin
						pc_q <= sum_abd;
					end else if (op == rjae_pkg::OP_CALLI) begin
						state_q <= S_MEM;
						done_q <= 1'b0;
					end else if (hi == rjae_pkg::GRP_BRANCH) begin
						if (take && lo[3]) begin
							state_q <= S_MEM;
							done_q <= 1'b0;
						end else if (take) begin
							pc_q <= tgt;
						end
					end else if (op == rjae_pkg::OP_XCHG) begin
						if (rb == rjae_pkg::REG_PC) begin
							pc_q <= vc_q;
						end else begin
							wr_q <= 1'b1;
							widx_q <= rb;
							wval_q <= vc_q;
						end
						state_q <= S_XCH;
						done_q <= 1'b0;
					end else if (hi == rjae_pkg::GRP_ARITH || hi == rjae_pkg::GRP_LOGIC) begin
						res_q <= alu_res;
						done_q <= 1'b0;
						if (div_start) begin
							state_q <= S_DIV;
						end else begin
							if (hi == rjae_pkg::GRP_ARITH && lo == rjae_pkg::LO_DIV) begin
								status_q <= rjae_pkg::ST_DIVZ;
							end
							state_q <= S_WB;
						end
					end
				end
				S_MEM: begin
					pc_q <= mem_rd_q;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_XCH: begin
					if (rc == rjae_pkg::REG_PC) begin
						pc_q <= vb_q;
					end else if (!wr_q) begin
						wr_q <= 1'b1;
						widx_q <= rc;
						wval_q <= vb_q;
					end
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DIV: begin
					if (div_done) begin
						res_q <= div_quo;
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (ra == rjae_pkg::REG_PC) begin
						pc_q <= res_q;
					end else begin
						wr_q <= 1'b1;
						widx_q <= ra;
						wval_q <= res_q;
					end
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign next_pc = pc_q;
	assign reg_written = wr_q;
	assign reg_index = widx_q;
	assign reg_value = wval_q;
endmodule

// ===== rtl/rjae_checker.sv =====
// port-level checks for the execute step unit, attached by bind
// depends only on the top level's ports
module rjae_props (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic        reg_written,
	input logic [3:0]  reg_index,
	input logic        cfg_valid,
	input logic        cfg_ready
);
	// an accepted request either finishes next cycle or keeps the unit busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("accepted request neither done nor busy");

	// a reported register write never names the program counter
	a_no_pc_report: assert property (@(posedge clk) disable iff (!arst_n)
		done && reg_written |-> reg_index != 4'd15)
		else $error("register write report names pc");

	// no register report means index zero
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !reg_written |-> reg_index == 4'd0)
		else $error("index set without write");

	// status code stays within its defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3)
		else $error("undefined status code");

	// the configuration register is never written during a step
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !busy)
		else $error("configuration taken while busy");
endmodule

bind risc_jump_alu_execute_step_unit rjae_props u_rjae_props (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.reg_written (reg_written),
	.reg_index   (reg_index),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready)
);

// ===== tb/rjae_checker.sv =====
// request monitor, step predictor and result comparator for the execute step unit
// depends on rjae_pkg; instantiated by tb_top beside the unit
`timescale 1ns / 1ps

module rjae_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        operation,
	input  logic [31:0] load_address,
	input  logic [31:0] load_word,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [31:0] next_pc,
	input  logic        reg_written,
	input  logic [3:0]  reg_index,
	input  logic [31:0] reg_value,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending
);
	localparam int QDEPTH = 8;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] next_pc;
		logic        reg_written;
		logic [3:0]  reg_index;
		logic [31:0] reg_value;
	} step_result_t;

	// expected results in request order
	step_result_t res_buf[QDEPTH];
	int wr_cnt;
	int rd_cnt;

	// shadow architectural state
	logic [31:0] gpr[0:14];
	logic [31:0] prog_ctr;
	logic [31:0] word_mem[0:1023];
	logic        is_halted;
	step_result_t cur;

	function automatic logic [31:0] read_reg(input logic [3:0] idx);
		if (idx == rjae_pkg::REG_PC)
			return prog_ctr;
		return gpr[idx];
	endfunction

	// only the first write is reported
	function automatic void write_reg(input logic [3:0] idx, input logic [31:0] val);
		if (idx == rjae_pkg::REG_PC) begin
			prog_ctr = val;
			return;
		end
		gpr[idx] = val;
		if (!cur.reg_written) begin
			cur.reg_written = 1'b1;
			cur.reg_index = idx;
			cur.reg_value = val;
		end
	endfunction

	function automatic step_result_t predict_step(input logic opn, input logic [31:0] addr,
			input logic [31:0] data);
		logic [31:0] ins, vb, vc, dsp, tgt, res;
		logic [7:0]  op;
		logic [3:0]  ra, rb, rc, hi, lo;
		logic        take;
		cur = '0;
		if (opn == rjae_pkg::OPN_LOAD) begin
			word_mem[addr[11:2]] = data;
			cur.status = is_halted ? rjae_pkg::ST_HALT : rjae_pkg::ST_OK;
		end else if (is_halted) begin
			cur.status = rjae_pkg::ST_HALT;
		end else begin
			ins = word_mem[prog_ctr[11:2]];
			op = ins[31:24];
			ra = ins[23:20];
			rb = ins[19:16];
			rc = ins[15:12];
			dsp = {{20{ins[11]}}, ins[11:0]};
			hi = op[7:4];
			lo = op[3:0];
			prog_ctr = prog_ctr + rjae_pkg::PC_STEP;
			vb = read_reg(rb);
			vc = read_reg(rc);
			if (op == rjae_pkg::OP_HALT) begin
				is_halted = 1'b1;
				cur.status = rjae_pkg::ST_HALT;
			end else if (op == rjae_pkg::OP_CALL) begin
				prog_ctr = read_reg(ra) + vb + dsp;
			end else if (op == rjae_pkg::OP_CALLI) begin
				tgt = read_reg(ra) + vb + dsp;
				prog_ctr = word_mem[tgt[11:2]];
			end else if (hi == rjae_pkg::GRP_BRANCH) begin
				tgt = read_reg(ra) + dsp;
				case (lo[2:0])
					rjae_pkg::BR_JMP: take = 1'b1;
					rjae_pkg::BR_EQ: take = (vb == vc);
					rjae_pkg::BR_NE: take = (vb != vc);
					rjae_pkg::BR_GT: take = (vb > vc);
					default: take = 1'b0;
				endcase
				if (lo > 4'd11 || (lo > 4'd3 && lo < 4'd8))
					take = 1'b0;
				if (take)
					prog_ctr = lo[3] ? word_mem[tgt[11:2]] : tgt;
			end else if (op == rjae_pkg::OP_XCHG) begin
				write_reg(rb, vc);
				write_reg(rc, vb);
			end else if (hi == rjae_pkg::GRP_ARITH || hi == rjae_pkg::GRP_LOGIC) begin
				res = '0;
				if (hi == rjae_pkg::GRP_ARITH) begin
					case (lo)
						rjae_pkg::LO_ADD: res = vb + vc;
						rjae_pkg::LO_SUB: res = vb - vc;
						rjae_pkg::LO_MUL: res = vb * vc;
						rjae_pkg::LO_DIV: begin
							if (vc == 32'd0)
								cur.status = rjae_pkg::ST_DIVZ;
							else
								res = vb / vc;
						end
						default: res = '0;
					endcase
				end else begin
					case (lo)
						rjae_pkg::LO_NOT: res = ~vb;
						rjae_pkg::LO_AND: res = vb & vc;
						rjae_pkg::LO_OR: res = vb | vc;
						rjae_pkg::LO_XOR: res = vb ^ vc;
						default: res = '0;
					endcase
				end
				write_reg(ra, res);
			end
		end
		cur.next_pc = prog_ctr;
		return cur;
	endfunction

	// predict on accepted requests and config writes, compare on done
	always @(posedge clk or negedge arst_n) begin
		step_result_t exp_r, got;
		if (!arst_n) begin
			for (int i = 0; i < 15; i++)
				gpr[i] = '0;
			prog_ctr = rjae_pkg::START_RESET;
			is_halted = 1'b0;
			wr_cnt = 0;
			rd_cnt = 0;
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				prog_ctr = cfg_data;
				is_halted = 1'b0;
			end
			if (done) begin
				got = '{status, next_pc, reg_written, reg_index, reg_value};
				if (wr_cnt == rd_cnt) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: %p", got);
				end else begin
					exp_r = res_buf[rd_cnt % QDEPTH];
					rd_cnt++;
					if (got !== exp_r) begin
						errors++;
						if (errors <= 10)
							$display("result mismatch: expected %p, actual %p", exp_r, got);
					end
				end
			end
			if (start && !busy) begin
				res_buf[wr_cnt % QDEPTH] = predict_step(operation, load_address, load_word);
				wr_cnt++;
			end
		end
		pending = wr_cnt - rd_cnt;
	end

endmodule

// ===== tb/tb_top.sv =====
// stimulus and verdict for the execute step unit: memory image, directed program, random steps
// depends on rjae_pkg, rjae_checker and the unit under test
`timescale 1ns / 1ps

module tb_top;
	localparam logic [7:0] OP_UNDEF = 8'hFF;
	localparam logic [7:0] OP_BR_UNUSED = 8'h34;
	localparam logic [7:0] OP_BR_UNUSED_IND = 8'h3C;
	localparam logic OPN_EXEC = 1'b1;
	localparam logic [31:0] BASE = rjae_pkg::START_RESET;

	logic        clk, arst_n, start, busy, operation, done, reg_written;
	logic        cfg_valid, cfg_ready;
	logic [31:0] load_address, load_word, next_pc, reg_value, cfg_data;
	logic [1:0]  status;
	logic [3:0]  reg_index;
	int          chk_errors, chk_pending;
	int          n_req, n_done, n_exec, n_load, n_cfg, n_halt, n_divz;
	logic        saw_halt;

	risc_jump_alu_execute_step_unit dut (
		.clk, .arst_n, .start, .busy, .operation, .load_address, .load_word,
		.done, .status, .next_pc, .reg_written, .reg_index, .reg_value,
		.cfg_valid, .cfg_ready, .cfg_data
	);

	rjae_checker u_checker (
		.clk, .arst_n, .start, .busy, .operation, .load_address, .load_word,
		.done, .status, .next_pc, .reg_written, .reg_index, .reg_value,
		.cfg_valid, .cfg_ready, .cfg_data, .errors(chk_errors), .pending(chk_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result bookkeeping for idle detection and the summary
	always @(posedge clk) begin
		if (done) begin
			n_done++;
			if (status == rjae_pkg::ST_HALT) begin
				saw_halt = 1'b1;
				n_halt++;
			end
			if (status == rjae_pkg::ST_DIVZ)
				n_divz++;
		end
	end

	function automatic logic [31:0] mk(input logic [7:0] op, input logic [3:0] a,
			input logic [3:0] b, input logic [3:0] c, input logic [11:0] d);
		return {op, a, b, c, d};
	endfunction

	// random instruction, weighted toward the supported opcodes
	function automatic logic [31:0] rand_instr();
		logic [7:0] op;
		case ($urandom_range(0, 19))
			0: op = ($urandom_range(0, 2) == 0) ? rjae_pkg::OP_HALT : rjae_pkg::OP_XCHG;
			1: op = rjae_pkg::OP_CALL;
			2: op = rjae_pkg::OP_CALLI;
			3, 4, 5: op = {rjae_pkg::GRP_BRANCH, 1'b0, 3'($urandom_range(0, 3))};
			6, 7: op = {rjae_pkg::GRP_BRANCH, 1'b1, 3'($urandom_range(0, 3))};
			8: op = {rjae_pkg::GRP_BRANCH, 4'($urandom)};
			9: op = rjae_pkg::OP_XCHG;
			10, 11, 12, 13: op = {rjae_pkg::GRP_ARITH, 4'($urandom_range(0, 3))};
			14, 15, 16: op = {rjae_pkg::GRP_LOGIC, 4'($urandom_range(0, 3))};
			17: op = {($urandom_range(0, 1) == 0) ? rjae_pkg::GRP_ARITH : rjae_pkg::GRP_LOGIC,
				4'($urandom)};
			default: op = 8'($urandom);
		endcase
		return {op, 24'($urandom)};
	endfunction

	// idle length before a request, mostly none or short
	function automatic int gap_len();
		int r;
		r = int'($urandom_range(0, 9));
		if (r >= 9)
			return int'($urandom_range(10, 40));
		if (r >= 6)
			return int'($urandom_range(1, 3));
		return 0;
	endfunction

	// drop the request lines
	task automatic drop_start();
		start <= 1'b0;
		operation <= 1'($urandom);
		load_address <= $urandom;
		load_word <= $urandom;
		@(negedge clk);
	endtask

	// one request, offered only while the unit is idle so the next edge takes it
	task automatic send(input logic opn, input logic [31:0] addr, input logic [31:0] data);
		int n;
		n = gap_len();
		if (n > 0 || busy) begin
			start <= 1'b0;
			operation <= 1'($urandom);
			load_address <= $urandom;
			load_word <= $urandom;
			repeat (n) @(negedge clk);
			while (busy)
				@(negedge clk);
		end
		start <= 1'b1;
		operation <= opn;
		load_address <= addr;
		load_word <= data;
		@(negedge clk);
		n_req++;
		if (opn == rjae_pkg::OPN_LOAD)
			n_load++;
		else
			n_exec++;
	endtask

	task automatic load_idx(input int idx, input logic [31:0] data);
		send(rjae_pkg::OPN_LOAD, {20'($urandom), idx[9:0], 2'($urandom)}, data);
	endtask

	task automatic wait_idle();
		drop_start();
		while (n_done != n_req)
			@(negedge clk);
		@(negedge clk);
	endtask

	// start address write, only with nothing outstanding
	task automatic write_start(input logic [31:0] value);
		wait_idle();
		while (!cfg_ready)
			@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		n_cfg++;
		saw_halt = 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= $urandom;
	endtask

	initial begin
		logic [31:0] prog[0:24];
		logic [31:0] sa;
		int drain;
		start = 1'b0;
		operation = 1'b0;
		load_address = '0;
		load_word = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		saw_halt = 1'b0;
		n_req = 0;
		n_done = 0;
		n_exec = 0;
		n_load = 0;
		n_cfg = 0;
		n_halt = 0;
		n_divz = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// whole memory gets an image so every fetch reads a loaded word
		for (int i = 0; i < 1024; i++)
			load_idx(i, ($urandom_range(0, 7) == 0) ? $urandom : rand_instr());

		// directed program from the reset start address
		prog[0] = mk({rjae_pkg::GRP_ARITH, rjae_pkg::LO_ADD}, 4'd1, 4'd15, 4'd15, 12'd0);
		prog[1] = mk({rjae_pkg::GRP_ARITH, rjae_pkg::LO_SUB}, 4'd2, 4'd0, 4'd15, 12'd0);
		prog[2] = mk({rjae_pkg::GRP_ARITH, rjae_pkg::LO_MUL}, 4'd3, 4'd2, 4'd2, 12'd0);
		// divide by zero
		prog[3] = mk({rjae_pkg::GRP_ARITH, rjae_pkg::LO_DIV}, 4'd4, 4'd3, 4'd0, 12'd0);
		prog[4] = mk({rjae_pkg::GRP_ARITH, rjae_pkg::LO_DIV}, 4'd5, 4'd3, 4'd1, 12'd0);
		prog[5] = mk({rjae_pkg::GRP_LOGIC, rjae_pkg::LO_NOT}, 4'd13, 4'd0, 4'd0, 12'd0);
		prog[6] = mk({rjae_pkg::GRP_LOGIC, rjae_pkg::LO_AND}, 4'd14, 4'd1, 4'd2, 12'd0);
		prog[7] = mk({rjae_pkg::GRP_LOGIC, rjae_pkg::LO_OR}, 4'd6, 4'd13, 4'd1, 12'd0);
		prog[8] = mk({rjae_pkg::GRP_LOGIC, rjae_pkg::LO_XOR}, 4'd7, 4'd13, 4'd2, 12'd0);
		// reserved alu codes clear A
		prog[9] = mk({rjae_pkg::GRP_ARITH, 4'h7}, 4'd8, 4'd1, 4'd2, 12'd0);
		prog[10] = mk({rjae_pkg::GRP_LOGIC, 4'hF}, 4'd9, 4'd1, 4'd2, 12'd0);
		prog[11] = mk(rjae_pkg::OP_XCHG, 4'd0, 4'd6, 4'd7, 12'd0);
		prog[12] = mk({rjae_pkg::GRP_BRANCH, 1'b0, rjae_pkg::BR_EQ}, 4'd15, 4'd0, 4'd0, 12'd4);
		prog[13] = mk(OP_BR_UNUSED, 4'd0, 4'd0, 4'd0, 12'd0);
		prog[14] = mk({rjae_pkg::GRP_BRANCH, 1'b0, rjae_pkg::BR_NE}, 4'd15, 4'd0, 4'd13,
			12'd0);
		prog[15] = mk({rjae_pkg::GRP_BRANCH, 1'b1, rjae_pkg::BR_JMP}, 4'd0, 4'd0, 4'd0,
			12'd64);
		prog[16] = BASE + 32'd68;
		prog[17] = mk(rjae_pkg::OP_CALL, 4'd15, 4'd0, 4'd0, 12'd4);
		prog[18] = mk(OP_BR_UNUSED_IND, 4'd0, 4'd0, 4'd0, 12'd0);
		prog[19] = mk(rjae_pkg::OP_CALLI, 4'd0, 4'd0, 4'd0, 12'd80);
		prog[20] = BASE + 32'd84;
		prog[21] = mk({rjae_pkg::GRP_BRANCH, 1'b1, rjae_pkg::BR_GT}, 4'd0, 4'd13, 4'd0,
			12'd88);
		prog[22] = BASE + 32'd92;
		prog[23] = mk(OP_UNDEF, 4'd15, 4'd15, 4'd15, 12'hFFF);
		prog[24] = mk(rjae_pkg::OP_HALT, 4'd0, 4'd0, 4'd0, 12'd0);
		for (int i = 0; i < 25; i++)
			load_idx(i, prog[i]);
		write_start(BASE);
		repeat (21)
			send(OPN_EXEC, $urandom, $urandom);
		load_idx(40, rand_instr());                         // load while halted

		// address extremes, including wrap of the program counter
		write_start(32'hFFFF_FFFC);
		repeat (5)
			send(OPN_EXEC, $urandom, $urandom);
		write_start(32'h0000_0000);
		repeat (5)
			send(OPN_EXEC, $urandom, $urandom);

		// random steps with occasional reloads and restarts
		for (int k = 0; k < 450; k++) begin
			if (saw_halt || $urandom_range(0, 59) == 0) begin
				case ($urandom_range(0, 3))
					0: sa = '0;
					1: sa = 32'hFFFF_FFFF;
					default: sa = $urandom;
				endcase
				write_start(sa);
			end
			if ($urandom_range(0, 6) == 0)
				send(rjae_pkg::OPN_LOAD, $urandom,
					($urandom_range(0, 1) == 0) ? $urandom : rand_instr());
			else
				send(OPN_EXEC, $urandom, $urandom);
		end

		drop_start();
		drain = 0;
		while (n_done != n_req && drain < 2000) begin
			@(negedge clk);
			drain++;
		end
		repeat (60) @(negedge clk);

		$display("covered %0d steps, %0d memory loads, %0d start writes", n_exec, n_load, n_cfg);
		$display("halted results %0d, divide-by-zero results %0d", n_halt, n_divz);
		if (chk_errors == 0 && chk_pending == 0 && n_done == n_req)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit
	initial begin
		#8ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
